>>> rtl/damped_least_squares_joint_rates_unit_defines.svh
// assertion macros for the joint-rate unit
`ifndef DAMPED_LEAST_SQUARES_JOINT_RATES_UNIT_DEFINES_SVH
`define DAMPED_LEAST_SQUARES_JOINT_RATES_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, quiet during rst
`define DLSQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, quiet during rst
`define DLSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dlsq_pkg.sv
package dlsq_pkg;

  localparam int MAX_JOINTS = 6;
  localparam int FRAC_BITS  = 16;
  localparam int IN_COLS    = 6;
  // wide enough for 0..6, the full joint range plus the error slot
  localparam int IDX_W      = 4;

  localparam logic [30:0] DAMPING_RST = 31'd655;
  localparam logic [30:0] GAIN_RST    = 31'd655360;
  localparam logic [2:0]  JOINTS_RST  = 3'd6;

  localparam logic [1:0] REG_DAMPING = 2'd0;
  localparam logic [1:0] REG_GAIN    = 2'd1;
  localparam logic [1:0] REG_JOINTS  = 2'd2;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACC, OP_D2, OP_G, OP_DIV, OP_MULA, OP_MULB,
    OP_LOADS, OP_BSUB, OP_DIVX, OP_CLR
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_D2, S_G, S_PIV, S_DIV, S_MULA, S_MULB,
    S_LOADS, S_BSUB, S_DIVX, S_CLR, S_OUT
  } state_t;

  typedef struct packed {
    op_t                op;
    logic               start;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   lo;
    logic [IDX_W-1:0]   hi;
    logic signed [63:0] opnd;
    logic [63:0]        divisor;
  } lane_cmd_t;

  typedef struct packed {
    logic               mul_done;
    logic               div_done;
    logic signed [63:0] rd;
    logic signed [63:0] bv;
    logic signed [63:0] quo;
  } lane_st_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? S64_MIN : S64_MAX;
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
    sat_neg = (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    sat_sub = sat_add(a, sat_neg(b));
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] a);
    mag64 = a[63] ? (~a + 64'd1) : a;
  endfunction

  // clamp a 64-bit magnitude with sign into signed 64 bits
  function automatic logic signed [63:0] pack_s64(input logic neg, input logic [63:0] m,
                                                  input logic ovf);
    logic [63:0] lim;
    logic [63:0] mm;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    mm  = (ovf || (m > lim)) ? lim : m;
    pack_s64 = neg ? (~mm + 64'd1) : mm;
  endfunction

  function automatic logic [31:0] sat_rate(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      sat_rate = 32'h7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      sat_rate = 32'h8000_0000;
    end else begin
      sat_rate = x[31:0];
    end
  endfunction

endpackage

>>> rtl/dlsq_mul.sv
// fixed-point product, four 32x32 partial products over successive cycles
module dlsq_mul #(
  parameter int FRAC_BITS = dlsq_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] res
);

  logic [63:0]  xm, ym;
  logic         neg;
  logic         run;
  logic [2:0]   cnt;
  logic [63:0]  pp;
  logic [6:0]   ppsh;
  logic         ppv;
  logic [127:0] acc;
  logic [31:0]  opx, opy;
  logic [6:0]   sh;
  logic         ovf;
  logic [63:0]  mq;

  // cnt 0: lo*lo, 1: lo*hi, 2: hi*lo, 3: hi*hi
  assign opx = cnt[1] ? xm[63:32] : xm[31:0];
  assign opy = cnt[0] ? ym[63:32] : ym[31:0];
  assign sh  = {cnt[1] & cnt[0], cnt[1] ^ cnt[0], 5'd0};
  assign ovf = |acc[127:64+FRAC_BITS];
  assign mq  = acc[63+FRAC_BITS:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      ppv  <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xm  <= dlsq_pkg::mag64(a);
        ym  <= dlsq_pkg::mag64(b);
        neg <= a[63] ^ b[63];
        acc <= 128'd0;
        cnt <= 3'd0;
        run <= 1'b1;
        ppv <= 1'b0;
      end else if (run) begin
        pp   <= opx * opy;
        ppsh <= sh;
        ppv  <= (cnt < 3'd4);
        if (ppv) begin
          acc <= acc + ({64'd0, pp} << ppsh);
        end
        if (cnt == 3'd5) begin
          res  <= dlsq_pkg::pack_s64(neg, mq, ovf);
          done <= 1'b1;
          run  <= 1'b0;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

endmodule

>>> rtl/dlsq_div.sv
// fixed-point quotient, restoring division one bit a cycle
module dlsq_div #(
  parameter int FRAC_BITS = dlsq_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic [63:0]        d,
  output logic               done,
  output logic signed [63:0] res
);

  localparam int NW = 64 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num;
  logic [NW-1:0] q;
  logic [63:0]   rem;
  logic [63:0]   dv;
  logic          neg;
  logic          run;
  logic [CW-1:0] cnt;
  logic [64:0]   t;
  logic          ge;
  logic [64:0]   diff;

  assign t    = {rem, num[NW-1]};
  assign ge   = (t >= {1'b0, dv});
  assign diff = t - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num <= {dlsq_pkg::mag64(a), {FRAC_BITS{1'b0}}};
        q   <= '0;
        rem <= 64'd0;
        dv  <= d;
        neg <= a[63];
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (cnt == CW'(NW)) begin
          res  <= dlsq_pkg::pack_s64(neg, q[63:0], |q[NW-1:64]);
          done <= 1'b1;
          run  <= 1'b0;
        end else begin
          num <= {num[NW-2:0], 1'b0};
          rem <= ge ? diff[63:0] : t[63:0];
          q   <= {q[NW-2:0], ge};
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

endmodule

>>> rtl/dlsq_lane.sv
// one lane owns one row of the normal matrix and its rhs element
module dlsq_lane #(
  parameter int MAX_JOINTS = dlsq_pkg::MAX_JOINTS,
  parameter int FRAC_BITS  = dlsq_pkg::FRAC_BITS,
  parameter int LANE       = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  dlsq_pkg::lane_cmd_t cmd,
  input  logic signed [31:0]  own_row,
  output dlsq_pkg::lane_st_t  st
);

  localparam int IW = dlsq_pkg::IDX_W;
  localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam logic [IW-1:0] LANE_I = IW'(LANE);

  logic signed [63:0] arow [MAX_JOINTS];
  logic signed [63:0] bv;
  logic signed [63:0] f;
  logic signed [63:0] s;
  logic [AW-1:0]      ai;
  logic               en;
  logic signed [63:0] mul_a;
  logic signed [63:0] div_a;
  logic               mstart, dstart;
  logic               mdone, ddone;
  logic signed [63:0] mres, dres;

  assign ai = cmd.idx[AW-1:0];
  assign en = (cmd.lo <= LANE_I) && (LANE_I < cmd.hi);

  always_comb begin
    case (cmd.op)
      dlsq_pkg::OP_ACC:  mul_a = 64'(own_row);
      dlsq_pkg::OP_G:    mul_a = bv;
      dlsq_pkg::OP_MULA: mul_a = f;
      dlsq_pkg::OP_MULB: mul_a = f;
      dlsq_pkg::OP_BSUB: mul_a = arow[ai];
      default:           mul_a = cmd.opnd;
    endcase
  end

  assign div_a  = (cmd.op == dlsq_pkg::OP_DIV) ? arow[ai] : s;
  assign dstart = cmd.start && ((cmd.op == dlsq_pkg::OP_DIV) ||
                                (cmd.op == dlsq_pkg::OP_DIVX));
  assign mstart = cmd.start && !dstart;

  dlsq_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(mul_a), .b(cmd.opnd),
    .done(mdone), .res(mres)
  );

  dlsq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .a(div_a), .d(cmd.divisor),
    .done(ddone), .res(dres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < MAX_JOINTS; c++) begin
        arow[c] <= 64'sd0;
      end
      bv <= 64'sd0;
    end else begin
      if (cmd.op == dlsq_pkg::OP_CLR) begin
        for (int c = 0; c < MAX_JOINTS; c++) begin
          arow[c] <= 64'sd0;
        end
        bv <= 64'sd0;
      end else if (cmd.op == dlsq_pkg::OP_LOADS) begin
        if (en) begin
          s <= bv;
        end
      end else if (mdone && en) begin
        case (cmd.op)
          dlsq_pkg::OP_ACC: begin
            if (cmd.idx == IW'(MAX_JOINTS)) begin
              bv <= dlsq_pkg::sat_add(bv, mres);
            end else begin
              arow[ai] <= dlsq_pkg::sat_add(arow[ai], mres);
            end
          end
          dlsq_pkg::OP_D2:   arow[LANE] <= dlsq_pkg::sat_add(arow[LANE], mres);
          dlsq_pkg::OP_G:    bv <= dlsq_pkg::sat_neg(mres);
          dlsq_pkg::OP_MULA: arow[ai] <= dlsq_pkg::sat_sub(arow[ai], mres);
          dlsq_pkg::OP_MULB: bv <= dlsq_pkg::sat_sub(bv, mres);
          dlsq_pkg::OP_BSUB: s <= dlsq_pkg::sat_sub(s, mres);
          default: ;
        endcase
      end else if (ddone && (cmd.op == dlsq_pkg::OP_DIV)) begin
        f <= dres;
      end
    end
  end

  assign st.mul_done = mdone;
  assign st.div_done = ddone;
  assign st.rd       = arow[ai];
  assign st.bv       = bv;
  assign st.quo      = dres;

endmodule

>>> rtl/damped_least_squares_joint_rates_unit.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-------------------------------------------
// in       | to unit   | in_valid / in_stall  | jac_col_0..5, err_elem, row_last
// out      | from unit | out_valid / out_stall| joint_index, joint_rate, run_end, singular
// cfg      | to unit   | cfg_write            | cfg_index, cfg_data
//
// a row beat takes one product per column per lane,
// each product is a start cycle, four 32x32 partial products and a wind-down
// a last row adds the solve: 2*n-1 divisions, one bit a cycle in the lane divider, plus
// n*n+1 products and 2*n+1 single steps; stores are cleared after the solve, before the
// first rate beat; rst is synchronous; in_stall stays high from an accepted beat until
// its row is folded in, or for a last row until the last rate is taken
`include "damped_least_squares_joint_rates_unit_defines.svh"

module damped_least_squares_joint_rates_unit #(
  parameter int MAX_JOINTS = dlsq_pkg::MAX_JOINTS,
  parameter int FRAC_BITS  = dlsq_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  // row beats
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] jac_col_0,
  input  logic signed [31:0] jac_col_1,
  input  logic signed [31:0] jac_col_2,
  input  logic signed [31:0] jac_col_3,
  input  logic signed [31:0] jac_col_4,
  input  logic signed [31:0] jac_col_5,
  input  logic signed [31:0] err_elem,
  input  logic               row_last,
  // rate beats
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         joint_index,
  output logic signed [31:0] joint_rate,
  output logic               run_end,
  output logic               singular
);

  localparam int IW = dlsq_pkg::IDX_W;
  localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam logic [IW-1:0] MJ = IW'(MAX_JOINTS);

  // configuration registers
  logic [30:0] damping;
  logic [30:0] gain;
  logic [2:0]  active_joints;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping       <= dlsq_pkg::DAMPING_RST;
      gain          <= dlsq_pkg::GAIN_RST;
      active_joints <= dlsq_pkg::JOINTS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        dlsq_pkg::REG_DAMPING: damping       <= cfg_data;
        dlsq_pkg::REG_GAIN:    gain          <= cfg_data;
        dlsq_pkg::REG_JOINTS:  active_joints <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // joint count clamped to 1..MAX_JOINTS
  logic [IW-1:0] nj;
  always_comb begin
    if (active_joints == 3'd0) begin
      nj = IW'(1);
    end else if (IW'(active_joints) > MJ) begin
      nj = MJ;
    end else begin
      nj = IW'(active_joints);
    end
  end

  // captured row beat
  logic signed [31:0] jin [dlsq_pkg::IN_COLS];
  logic signed [31:0] rowr [MAX_JOINTS];
  logic signed [31:0] errr;
  logic               lastr;
  logic               in_acc;

  assign jin[0] = jac_col_0;
  assign jin[1] = jac_col_1;
  assign jin[2] = jac_col_2;
  assign jin[3] = jac_col_3;
  assign jin[4] = jac_col_4;
  assign jin[5] = jac_col_5;
  assign in_acc = in_valid && !in_stall;

  for (genvar c = 0; c < MAX_JOINTS; c++) begin : g_row
    if (c < dlsq_pkg::IN_COLS) begin : g_in
      always_ff @(posedge clk) begin
        if (in_acc) begin
          rowr[c] <= jin[c];
        end
      end
    end else begin : g_zero
      // columns past the input fields read as zero
      always_ff @(posedge clk) begin
        if (in_acc) begin
          rowr[c] <= 32'sd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      errr  <= err_elem;
      lastr <= row_last;
    end
  end

  // sequencer state
  dlsq_pkg::state_t state, state_next;
  logic          busy, busy_next;
  logic [IW-1:0] j, j_next;
  logic [IW-1:0] k, k_next;
  logic [IW-1:0] r, r_next;
  logic [IW-1:0] oi, oi_next;
  logic          sing, sing_next;
  logic          ov_next;
  logic [2:0]    oidx_next;
  logic [31:0]   orate_next;
  logic          oend_next, osing_next;
  logic          start;
  logic          x_we;

  // lanes and merge
  dlsq_pkg::lane_cmd_t cmd;
  dlsq_pkg::lane_st_t  lst [MAX_JOINTS];
  logic [AW-1:0]       sel;
  logic signed [63:0]  m_rd, m_bv, m_quo;
  logic                mdone, ddone;
  logic signed [63:0]  xr [MAX_JOINTS];

  for (genvar g = 0; g < MAX_JOINTS; g++) begin : g_lane
    dlsq_lane #(
      .MAX_JOINTS(MAX_JOINTS), .FRAC_BITS(FRAC_BITS), .LANE(g)
    ) u_lane (
      .clk(clk), .rst(rst), .cmd(cmd), .own_row(rowr[g]), .st(lst[g])
    );
  end

  // merge select: current row in the load and divide steps of back-substitution, pivot lane otherwise
  assign sel   = (state == dlsq_pkg::S_DIVX || state == dlsq_pkg::S_LOADS) ?
                 r[AW-1:0] : k[AW-1:0];
  assign m_rd  = lst[sel].rd;
  assign m_bv  = lst[sel].bv;
  assign m_quo = lst[sel].quo;
  // lanes run in lockstep, lane 0 paces the sequencer
  assign mdone = lst[0].mul_done;
  assign ddone = lst[0].div_done;

  // command broadcast
  always_comb begin
    cmd.op      = dlsq_pkg::OP_NONE;
    cmd.start   = start;
    cmd.idx     = '0;
    cmd.lo      = '0;
    cmd.hi      = MJ;
    cmd.opnd    = 64'sd0;
    cmd.divisor = m_rd;
    case (state)
      dlsq_pkg::S_ACC: begin
        cmd.op   = dlsq_pkg::OP_ACC;
        cmd.idx  = j;
        // last column slot folds the error into the rhs
        cmd.opnd = (j == MJ) ? 64'(errr) : 64'(rowr[j[AW-1:0]]);
      end
      dlsq_pkg::S_D2: begin
        cmd.op   = dlsq_pkg::OP_D2;
        cmd.opnd = {33'd0, damping};
      end
      dlsq_pkg::S_G: begin
        cmd.op   = dlsq_pkg::OP_G;
        cmd.opnd = {33'd0, gain};
      end
      dlsq_pkg::S_PIV: begin
        cmd.idx = k;
      end
      dlsq_pkg::S_DIV: begin
        cmd.op  = dlsq_pkg::OP_DIV;
        cmd.idx = k;
      end
      dlsq_pkg::S_MULA: begin
        cmd.op   = dlsq_pkg::OP_MULA;
        cmd.idx  = j;
        cmd.lo   = k + IW'(1);
        cmd.hi   = nj;
        cmd.opnd = m_rd;
      end
      dlsq_pkg::S_MULB: begin
        cmd.op   = dlsq_pkg::OP_MULB;
        cmd.lo   = k + IW'(1);
        cmd.hi   = nj;
        cmd.opnd = m_bv;
      end
      dlsq_pkg::S_LOADS: begin
        cmd.op = dlsq_pkg::OP_LOADS;
        cmd.lo = r;
        cmd.hi = r + IW'(1);
      end
      dlsq_pkg::S_BSUB: begin
        cmd.op   = dlsq_pkg::OP_BSUB;
        cmd.idx  = j;
        cmd.lo   = r;
        cmd.hi   = r + IW'(1);
        cmd.opnd = xr[j[AW-1:0]];
      end
      dlsq_pkg::S_DIVX: begin
        cmd.op  = dlsq_pkg::OP_DIVX;
        cmd.idx = r;
        cmd.lo  = r;
        cmd.hi  = r + IW'(1);
      end
      dlsq_pkg::S_CLR: begin
        cmd.op = dlsq_pkg::OP_CLR;
      end
      default: ;
    endcase
  end

  assign in_stall = (state != dlsq_pkg::S_IDLE);

  // next state and rate beat contents
  always_comb begin
    state_next = state;
    busy_next  = busy;
    j_next     = j;
    k_next     = k;
    r_next     = r;
    oi_next    = oi;
    sing_next  = sing;
    ov_next    = out_valid;
    oidx_next  = joint_index;
    orate_next = joint_rate;
    oend_next  = run_end;
    osing_next = singular;
    start      = 1'b0;
    x_we       = 1'b0;
    case (state)
      dlsq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = dlsq_pkg::S_ACC;
          busy_next  = 1'b0;
          j_next     = '0;
          sing_next  = 1'b0;
        end
      end
      dlsq_pkg::S_ACC: begin
        if (!busy) begin
          start     = 1'b1;
          busy_next = 1'b1;
        end else if (mdone) begin
          busy_next = 1'b0;
          if (j == MJ) begin
            j_next     = '0;
            state_next = lastr ? dlsq_pkg::S_D2 : dlsq_pkg::S_IDLE;
          end else begin
            j_next = j + IW'(1);
          end
        end
      end
      dlsq_pkg::S_D2: begin
        if (!busy) begin
          start     = 1'b1;
          busy_next = 1'b1;
        end else if (mdone) begin
          busy_next  = 1'b0;
          state_next = dlsq_pkg::S_G;
        end
      end
      dlsq_pkg::S_G: begin
        if (!busy) begin
          start     = 1'b1;
          busy_next = 1'b1;
        end else if (mdone) begin
          busy_next  = 1'b0;
          k_next     = '0;
          state_next = dlsq_pkg::S_PIV;
        end
      end
      dlsq_pkg::S_PIV: begin
        // non-positive pivot: zero rates, flag the run
        if (m_rd <= 64'sd0) begin
          sing_next  = 1'b1;
          state_next = dlsq_pkg::S_CLR;
        end else if (k == nj - IW'(1)) begin
          r_next     = nj - IW'(1);
          state_next = dlsq_pkg::S_LOADS;
        end else begin
          state_next = dlsq_pkg::S_DIV;
        end
      end
      dlsq_pkg::S_DIV: begin
        if (!busy) begin
          start     = 1'b1;
          busy_next = 1'b1;
        end else if (ddone) begin
          busy_next  = 1'b0;
          j_next     = k + IW'(1);
          state_next = dlsq_pkg::S_MULA;
        end
      end
      dlsq_pkg::S_MULA: begin
        if (!busy) begin
          start     = 1'b1;
          busy_next = 1'b1;
        end else if (mdone) begin
          busy_next = 1'b0;
          if (j == nj - IW'(1)) begin
            state_next = dlsq_pkg::S_MULB;
          end else begin
            j_next = j + IW'(1);
          end
        end
      end
      dlsq_pkg::S_MULB: begin
        if (!busy) begin
          start     = 1'b1;
          busy_next = 1'b1;
        end else if (mdone) begin
          busy_next  = 1'b0;
          k_next     = k + IW'(1);
          state_next = dlsq_pkg::S_PIV;
        end
      end
      dlsq_pkg::S_LOADS: begin
        j_next     = r + IW'(1);
        state_next = (r == nj - IW'(1)) ? dlsq_pkg::S_DIVX : dlsq_pkg::S_BSUB;
      end
      dlsq_pkg::S_BSUB: begin
        if (!busy) begin
          start     = 1'b1;
          busy_next = 1'b1;
        end else if (mdone) begin
          busy_next = 1'b0;
          if (j == nj - IW'(1)) begin
            state_next = dlsq_pkg::S_DIVX;
          end else begin
            j_next = j + IW'(1);
          end
        end
      end
      dlsq_pkg::S_DIVX: begin
        if (!busy) begin
          start     = 1'b1;
          busy_next = 1'b1;
        end else if (ddone) begin
          busy_next = 1'b0;
          x_we      = 1'b1;
          if (r == '0) begin
            state_next = dlsq_pkg::S_CLR;
          end else begin
            r_next     = r - IW'(1);
            state_next = dlsq_pkg::S_LOADS;
          end
        end
      end
      dlsq_pkg::S_CLR: begin
        oi_next    = '0;
        ov_next    = 1'b1;
        oidx_next  = 3'd0;
        orate_next = sing ? 32'd0 : dlsq_pkg::sat_rate(xr[0]);
        oend_next  = (nj == IW'(1));
        osing_next = sing;
        state_next = dlsq_pkg::S_OUT;
      end
      dlsq_pkg::S_OUT: begin
        if (!out_stall) begin
          if (oi == nj - IW'(1)) begin
            ov_next    = 1'b0;
            state_next = dlsq_pkg::S_IDLE;
          end else begin
            oi_next    = oi + IW'(1);
            oidx_next  = 3'(oi + IW'(1));
            orate_next = sing ? 32'd0 : dlsq_pkg::sat_rate(xr[AW'(oi + IW'(1))]);
            oend_next  = (oi + IW'(1) == nj - IW'(1));
          end
        end
      end
      default: state_next = dlsq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dlsq_pkg::S_IDLE;
      busy      <= 1'b0;
      j         <= '0;
      k         <= '0;
      r         <= '0;
      oi        <= '0;
      sing      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      busy      <= busy_next;
      j         <= j_next;
      k         <= k_next;
      r         <= r_next;
      oi        <= oi_next;
      sing      <= sing_next;
      out_valid <= ov_next;
    end
  end

  // rate beat payload and solved rates
  always_ff @(posedge clk) begin
    joint_index <= oidx_next;
    joint_rate  <= orate_next;
    run_end     <= oend_next;
    singular    <= osing_next;
    if (x_we) begin
      xr[r[AW-1:0]] <= m_quo;
    end
  end

  // rate beats only come out of the output phase
  `DLSQ_ASSERT_NOW(a_out_phase, out_valid, state == dlsq_pkg::S_OUT, "rate beat outside output phase")
  // a singular run carries zero rates
  `DLSQ_ASSERT_NOW(a_sing_zero, out_valid && singular, joint_rate == 32'sd0, "singular run with nonzero rate")
  // the run end mark sits on the highest active joint
  `DLSQ_ASSERT_NOW(a_run_end, out_valid && run_end, oi == nj - 4'd1, "run end on wrong joint")
  // an accepted row beat starts accumulation
  `DLSQ_ASSERT_NEXT(a_row_start, in_valid && !in_stall, state == dlsq_pkg::S_ACC, "row beat not folded in")

endmodule
